// ===== rtl/lcabl_pkg.sv =====
// Shared types and constants for the binary-lifting LCA core.
// Holds field widths, parameter defaults and the controller/datapath command set.
// Depends on nothing; every other file imports it.
package lcabl_pkg;

    localparam int NODE_W          = 10;
    localparam int DEPTH_W         = 10;
    localparam int DIST_W          = 11;
    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 10;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Register-update operation of the datapath for one cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LD_INIT,
        OP_MID,
        OP_DEPTH_A,
        OP_SWAP,
        OP_UP,
        OP_P1,
        OP_P2,
        OP_L_EQ,
        OP_L_PAR,
        OP_RESULT
    } t_dp_op;

    typedef enum logic [1:0] {
        AW_NONE,
        AW_CLEAR,
        AW_PARENT,
        AW_ROW
    } t_anc_wr;

    typedef enum logic [1:0] {
        DW_NONE,
        DW_CLEAR,
        DW_LOAD
    } t_dep_wr;

    typedef enum logic [2:0] {
        DR_NONE,
        DR_A,
        DR_B,
        DR_ANC0,
        DR_X
    } t_dep_rd;

    typedef enum logic [1:0] {
        AR_NONE,
        AR_MID,
        AR_XY
    } t_anc_rd;

    typedef struct packed {
        t_dp_op  op;
        t_anc_wr anc_wr;
        t_dep_wr dep_wr;
        t_dep_rd dep_rd;
        t_anc_rd anc_rd;
        logic    clr_adv;
    } t_cmd;

    typedef struct packed {
        logic a_zero;
        logic xy_eq;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/lcabl_dpath.sv =====
// Datapath of the binary-lifting LCA core: ancestor and depth memories,
// working node registers and the result register.
// Depends on lcabl_pkg; driven by lcabl_ctrl commands.
module lcabl_dpath #(
    parameter int MAX_NODES   = lcabl_pkg::DEF_MAX_NODES,
    parameter int LIFT_LEVELS = lcabl_pkg::DEF_LIFT_LEVELS,
    parameter int LW          = $clog2(LIFT_LEVELS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcabl_pkg::t_cmd                   i_cmd,
    input  logic [LW-1:0]                     i_rd_lvl,
    input  logic [LW-1:0]                     i_wr_lvl,
    input  logic [lcabl_pkg::NODE_W-1:0]      i_node_a,
    input  logic [lcabl_pkg::NODE_W-1:0]      i_node_b,
    output lcabl_pkg::t_status                o_status,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_stall,
    output logic [lcabl_pkg::NODE_W-1:0]      o_common_ancestor,
    output logic [lcabl_pkg::DIST_W-1:0]      o_path_distance
);
    import lcabl_pkg::*;

    localparam int NW        = $clog2(MAX_NODES);
    localparam int ANC_DEPTH = MAX_NODES * LIFT_LEVELS;
    localparam int AW        = $clog2(ANC_DEPTH);
    localparam int NODE_SPAN = (1 << NODE_W) - 1;

    logic [NW-1:0]      r_anc_mem [ANC_DEPTH];
    logic [DEPTH_W-1:0] r_dep_mem [MAX_NODES];

    logic [NW-1:0]      r_anc_q0, r_anc_q1;
    logic [DEPTH_W-1:0] r_dep_q;
    logic [NW-1:0]      r_a, r_b, r_mid, r_x, r_y, r_up, r_l;
    logic [DEPTH_W-1:0] r_da, r_db, r_dy;
    logic [NW-1:0]      r_clr_node;
    logic               r_out_valid;
    logic [NODE_W-1:0]  r_out_anc;
    logic [DIST_W-1:0]  r_out_dist;

    logic [NW-1:0]      n_x, n_y, rd0_node, anc_wnode, dep_raddr, dep_waddr;
    logic [NW-1:0]      anc_wdata;
    logic [AW-1:0]      anc_raddr0, anc_raddr1, anc_waddr;
    logic               anc_we, anc_re, dep_we, dep_re;
    logic [DEPTH_W-1:0] dep_wdata;
    logic [DIST_W-1:0]  depth_sum, depth_twice, path_len;

    // Reduce a node number modulo the table size by constant-shifted subtracts
    function automatic logic [NW-1:0] f_reduce(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        r = v;
        for (int s = NODE_W - 1; s >= 0; s--) begin
            if ((MAX_NODES << s) <= NODE_SPAN) begin
                if (r >= NODE_W'(MAX_NODES << s)) begin
                    r = r - NODE_W'(MAX_NODES << s);
                end
            end
        end
        return NW'(r);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] node,
                                              input logic [LW-1:0] lvl);
        return AW'(32'(node) * LIFT_LEVELS + 32'(lvl));
    endfunction

    // Next lifting position for the decide steps
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        case (i_cmd.op)
            OP_P1: begin
                if (r_dep_q >= r_dy) begin
                    n_x = r_up;
                end
            end
            OP_P2: begin
                if (r_anc_q0 != r_anc_q1) begin
                    n_x = r_anc_q0;
                    n_y = r_anc_q1;
                end
            end
            default: ;
        endcase
    end

    assign rd0_node   = (i_cmd.anc_rd == AR_MID) ? r_mid : n_x;
    assign anc_re     = (i_cmd.anc_rd != AR_NONE);
    assign anc_raddr0 = f_addr(rd0_node, i_rd_lvl);
    assign anc_raddr1 = f_addr(n_y, i_rd_lvl);

    always_comb begin
        anc_we    = 1'b1;
        anc_wnode = r_a;
        anc_wdata = r_anc_q0;
        case (i_cmd.anc_wr)
            AW_CLEAR: begin
                anc_wnode = r_clr_node;
                anc_wdata = '0;
            end
            AW_PARENT: anc_wdata = r_b;
            AW_ROW:    anc_wdata = r_anc_q0;
            default:   anc_we = 1'b0;
        endcase
    end
    assign anc_waddr = f_addr(anc_wnode, i_wr_lvl);

    always_comb begin
        dep_we    = 1'b1;
        dep_waddr = r_a;
        dep_wdata = (r_dep_q == DEPTH_MAX) ? DEPTH_MAX : r_dep_q + DEPTH_W'(1);
        case (i_cmd.dep_wr)
            DW_CLEAR: begin
                dep_waddr = r_clr_node;
                dep_wdata = '0;
            end
            DW_LOAD: ;
            default: dep_we = 1'b0;
        endcase
    end

    always_comb begin
        dep_re    = 1'b1;
        dep_raddr = r_a;
        case (i_cmd.dep_rd)
            DR_A:    dep_raddr = r_a;
            DR_B:    dep_raddr = r_b;
            DR_ANC0: dep_raddr = r_anc_q0;
            DR_X:    dep_raddr = r_x;
            default: dep_re = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            r_anc_mem[anc_waddr] <= anc_wdata;
        end
        if (anc_re) begin
            r_anc_q0 <= r_anc_mem[anc_raddr0];
            r_anc_q1 <= r_anc_mem[anc_raddr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_dep_mem[dep_waddr] <= dep_wdata;
        end
        if (dep_re) begin
            r_dep_q <= r_dep_mem[dep_raddr];
        end
    end

    // Distance: depth(a) + depth(b) - 2*depth(lca), floored at zero
    assign depth_sum   = DIST_W'(r_da) + DIST_W'(r_db);
    assign depth_twice = {r_dep_q, 1'b0};
    assign path_len    = (depth_sum >= depth_twice) ? depth_sum - depth_twice : '0;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_a <= f_reduce(i_node_a);
                r_b <= f_reduce(i_node_b);
            end
            OP_LD_INIT: r_mid <= r_b;
            OP_MID:     r_mid <= r_anc_q0;
            OP_DEPTH_A: r_da  <= r_dep_q;
            OP_SWAP: begin
                r_db <= r_dep_q;
                if (r_da < r_dep_q) begin
                    r_x  <= r_b;
                    r_y  <= r_a;
                    r_dy <= r_da;
                end else begin
                    r_x  <= r_a;
                    r_y  <= r_b;
                    r_dy <= r_dep_q;
                end
            end
            OP_UP: r_up <= r_anc_q0;
            OP_P1, OP_P2: begin
                r_x <= n_x;
                r_y <= n_y;
            end
            OP_L_EQ:  r_l <= r_x;
            OP_L_PAR: r_l <= r_anc_q0;
            OP_RESULT: begin
                r_out_anc  <= NODE_W'(r_l);
                r_out_dist <= path_len;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_node  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_adv) begin
                r_clr_node <= r_clr_node + NW'(1);
            end
            if (i_cmd.op == OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.a_zero   = (r_a == '0);
    assign o_status.xy_eq    = (r_x == r_y);
    assign o_status.clr_last = (r_clr_node == NW'(MAX_NODES - 1));
    assign o_status.out_free = !r_out_valid || !i_rsp_stall;

    assign o_rsp_valid       = r_out_valid;
    assign o_common_ancestor = r_out_anc;
    assign o_path_distance   = r_out_dist;

endmodule

// ===== rtl/lcabl_ctrl.sv =====
// Sequencer of the binary-lifting LCA core: clearing sweep, load row fill
// and the two lifting passes of a query.
// Depends on lcabl_pkg; commands lcabl_dpath.
module lcabl_ctrl #(
    parameter int LIFT_LEVELS = lcabl_pkg::DEF_LIFT_LEVELS,
    parameter int LW          = $clog2(LIFT_LEVELS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_type,
    output logic               o_req_stall,
    input  lcabl_pkg::t_status i_status,
    output lcabl_pkg::t_cmd    o_cmd,
    output logic [LW-1:0]      o_rd_lvl,
    output logic [LW-1:0]      o_wr_lvl
);
    import lcabl_pkg::*;

    localparam logic [LW-1:0] K_LAST = LW'(LIFT_LEVELS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_START,
        S_LD_DEP,
        S_LD_ROW,
        S_LD_RD,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_SWAP,
        S_P1_ANC,
        S_P1_DEP,
        S_P1_DEC,
        S_P2_CHK,
        S_P2_DEC,
        S_P2_PAR,
        S_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_k, n_k;
    logic          r_stall;

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        o_cmd.op      = OP_NONE;
        o_cmd.anc_wr  = AW_NONE;
        o_cmd.dep_wr  = DW_NONE;
        o_cmd.dep_rd  = DR_NONE;
        o_cmd.anc_rd  = AR_NONE;
        o_cmd.clr_adv = 1'b0;
        o_rd_lvl      = r_k;
        o_wr_lvl      = r_k;
        case (r_state)
            S_CLEAR: begin
                o_cmd.anc_wr = AW_CLEAR;
                if (r_k == '0) begin
                    o_cmd.dep_wr = DW_CLEAR;
                end
                if (r_k == K_LAST) begin
                    n_k           = '0;
                    o_cmd.clr_adv = 1'b1;
                    if (i_status.clr_last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_k = r_k + LW'(1);
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = i_req_type ? S_Q_RDA : S_LD_START;
                end
            end
            S_LD_START: begin
                if (i_status.a_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op     = OP_LD_INIT;
                    o_cmd.anc_wr = AW_PARENT;
                    o_cmd.dep_rd = DR_B;
                    o_wr_lvl     = '0;
                    n_k          = LW'(1);
                    n_state      = S_LD_DEP;
                end
            end
            S_LD_DEP: begin
                o_cmd.dep_wr = DW_LOAD;
                o_cmd.anc_rd = AR_MID;
                o_rd_lvl     = r_k - LW'(1);
                n_state      = S_LD_ROW;
            end
            S_LD_ROW: begin
                o_cmd.op     = OP_MID;
                o_cmd.anc_wr = AW_ROW;
                if (r_k == K_LAST) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + LW'(1);
                    n_state = S_LD_RD;
                end
            end
            S_LD_RD: begin
                o_cmd.anc_rd = AR_MID;
                o_rd_lvl     = r_k - LW'(1);
                n_state      = S_LD_ROW;
            end
            S_Q_RDA: begin
                o_cmd.dep_rd = DR_A;
                n_state      = S_Q_RDB;
            end
            S_Q_RDB: begin
                o_cmd.op     = OP_DEPTH_A;
                o_cmd.dep_rd = DR_B;
                n_state      = S_Q_SWAP;
            end
            S_Q_SWAP: begin
                o_cmd.op = OP_SWAP;
                n_k      = K_LAST;
                n_state  = S_P1_ANC;
            end
            S_P1_ANC: begin
                o_cmd.anc_rd = AR_XY;
                n_state      = S_P1_DEP;
            end
            S_P1_DEP: begin
                o_cmd.op     = OP_UP;
                o_cmd.dep_rd = DR_ANC0;
                n_state      = S_P1_DEC;
            end
            S_P1_DEC: begin
                o_cmd.op = OP_P1;
                if (r_k == '0) begin
                    n_state = S_P2_CHK;
                end else begin
                    o_cmd.anc_rd = AR_XY;
                    o_rd_lvl     = r_k - LW'(1);
                    n_k          = r_k - LW'(1);
                    n_state      = S_P1_DEP;
                end
            end
            S_P2_CHK: begin
                if (i_status.xy_eq) begin
                    o_cmd.op     = OP_L_EQ;
                    o_cmd.dep_rd = DR_X;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.anc_rd = AR_XY;
                    o_rd_lvl     = K_LAST;
                    n_k          = K_LAST;
                    n_state      = S_P2_DEC;
                end
            end
            S_P2_DEC: begin
                o_cmd.op     = OP_P2;
                o_cmd.anc_rd = AR_XY;
                if (r_k == '0) begin
                    o_rd_lvl = '0;
                    n_state  = S_P2_PAR;
                end else begin
                    o_rd_lvl = r_k - LW'(1);
                    n_k      = r_k - LW'(1);
                end
            end
            S_P2_PAR: begin
                o_cmd.op     = OP_L_PAR;
                o_cmd.dep_rd = DR_ANC0;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_req_stall = r_stall;

endmodule

// ===== rtl/lca_binary_lifting_core.sv =====
// Top level of the binary-lifting lowest-common-ancestor core.
// Ties lcabl_ctrl (sequencer) to lcabl_dpath (memories and datapath).
// Depends on lcabl_pkg, lcabl_ctrl and lcabl_dpath.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+----------------------------------
//   request   | in        | i_req_valid / o_req_stall | i_req_type, i_node_a, i_node_b
//   response  | out       | o_rsp_valid / i_rsp_stall | o_common_ancestor, o_path_distance
//
// After reset the core sweeps both memories to zero, one ancestor entry per cycle,
// with o_req_stall high until the sweep is done.
// A load request writes the parent entry, then reads and writes each further level
// (one ancestor read and one write per level through the single-write ancestor
// memory); a query runs a dependent ancestor-then-depth read per level of the first
// lifting pass. Reset is synchronous, active low.
// A stalled response holds in the output register while the next request is taken.
module lca_binary_lifting_core #(
    parameter int MAX_NODES   = lcabl_pkg::DEF_MAX_NODES,
    parameter int LIFT_LEVELS = lcabl_pkg::DEF_LIFT_LEVELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_stall,
    input  logic                         i_req_type,
    input  logic [lcabl_pkg::NODE_W-1:0] i_node_a,
    input  logic [lcabl_pkg::NODE_W-1:0] i_node_b,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_stall,
    output logic [lcabl_pkg::NODE_W-1:0] o_common_ancestor,
    output logic [lcabl_pkg::DIST_W-1:0] o_path_distance
);
    import lcabl_pkg::*;

    localparam int LW = $clog2(LIFT_LEVELS);

    t_cmd          cmd;
    t_status       status;
    logic [LW-1:0] rd_lvl;
    logic [LW-1:0] wr_lvl;

    // Sequencer: clear sweep, load row fill, up to two lifting passes per query
    lcabl_ctrl #(
        .LIFT_LEVELS (LIFT_LEVELS),
        .LW          (LW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req_type),
        .o_req_stall (o_req_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_rd_lvl    (rd_lvl),
        .o_wr_lvl    (wr_lvl)
    );

    // Ancestor and depth memories, node registers, response register
    lcabl_dpath #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS),
        .LW          (LW)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_rd_lvl          (rd_lvl),
        .i_wr_lvl          (wr_lvl),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .o_status          (status),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_stall       (i_rsp_stall),
        .o_common_ancestor (o_common_ancestor),
        .o_path_distance   (o_path_distance)
    );

`ifndef SYNTH
    // Drop no response: the result register loads only when it is free
    a_result_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_RESULT |-> status.out_free)
        else $error("result loaded into an occupied response register");

    // Hold the memories still while a new request is captured
    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |-> (cmd.anc_wr == AW_NONE && cmd.dep_wr == DW_NONE))
        else $error("memory write in the request capture cycle");

    // A response appears only right after the sequencer finished a query
    a_rsp_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(cmd.op == OP_RESULT))
        else $error("response valid without a finished query");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lca_binary_lifting_core: drives load and query requests,
// predicts ancestor and distance in a small scoreboard class and checks each response.
// Depends on lcabl_pkg and the core RTL; reads no files.
module testbench;
    import lcabl_pkg::*;

    localparam int NODES        = DEF_MAX_NODES;
    localparam int LEVELS       = DEF_LIFT_LEVELS;
    localparam int DIST_CAP     = 2046;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int ITEM_TARGET  = 2000;

    // Request kinds carried on i_req_type
    localparam bit REQ_LOAD  = 1'b0;
    localparam bit REQ_QUERY = 1'b1;

    // Receiver behavior for one stretch of cycles
    typedef enum int {
        RSP_FREE,
        RSP_HOLD,
        RSP_MIXED
    } t_rsp_mode;

    typedef struct {
        bit [NODE_W-1:0] ancestor;
        bit [DIST_W-1:0] distance;
    } t_lca_answer;

    // Mirror of the core's tables; a query's answer is queued when the request is taken.
    class t_lca_scoreboard;
        bit [NODE_W-1:0]  ancestor_of [NODES][LEVELS];
        bit [DEPTH_W-1:0] depth_of [NODES];
        t_lca_answer      pending_answers [$];
        int               error_count = 0;

        // Lift the deeper node to the other's depth, then climb both in step.
        function bit [NODE_W-1:0] lowest_common(bit [NODE_W-1:0] x, bit [NODE_W-1:0] y);
            bit [NODE_W-1:0] swap;
            bit [NODE_W-1:0] up;
            bit [NODE_W-1:0] ux;
            bit [NODE_W-1:0] uy;
            int              k;
            if (depth_of[x] < depth_of[y]) begin
                swap = x;
                x    = y;
                y    = swap;
            end
            for (k = LEVELS - 1; k >= 0; k--) begin
                up = ancestor_of[x][k];
                if (depth_of[up] >= depth_of[y])
                    x = up;
            end
            if (x == y)
                return x;
            for (k = LEVELS - 1; k >= 0; k--) begin
                ux = ancestor_of[x][k];
                uy = ancestor_of[y][k];
                if (ux != uy) begin
                    x = ux;
                    y = uy;
                end
            end
            return ancestor_of[x][0];
        endfunction

        function void note_request(bit kind, bit [NODE_W-1:0] a, bit [NODE_W-1:0] b);
            t_lca_answer answer;
            int          d;
            int          k;
            if (kind == REQ_LOAD) begin
                // Node zero is the sentinel: drop the load
                if (a == '0)
                    return;
                d = int'(depth_of[b]) + 1;
                if (d > int'(DEPTH_MAX))
                    d = int'(DEPTH_MAX);
                depth_of[a]       = d[DEPTH_W-1:0];
                ancestor_of[a][0] = b;
                // The row is built in place, so a self-parent reads its own new entries
                for (k = 1; k < LEVELS; k++)
                    ancestor_of[a][k] = ancestor_of[ancestor_of[a][k-1]][k-1];
            end else begin
                answer.ancestor = lowest_common(a, b);
                d = int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[answer.ancestor]);
                if (d < 0)
                    d = 0;
                if (d > DIST_CAP)
                    d = DIST_CAP;
                answer.distance = d[DIST_W-1:0];
                pending_answers = {pending_answers, answer};
            end
        endfunction

        function void check_response(logic [NODE_W-1:0] ancestor, logic [DIST_W-1:0] distance);
            t_lca_answer want;
            if (pending_answers.size() == 0) begin
                $error("response with no query outstanding: common_ancestor=%0d path_distance=%0d",
                       ancestor, distance);
                error_count++;
                return;
            end
            want = pending_answers.pop_front();
            if (ancestor !== want.ancestor) begin
                $error("common_ancestor: expected %0d, got %0d", want.ancestor, ancestor);
                error_count++;
            end
            if (distance !== want.distance) begin
                $error("path_distance: expected %0d, got %0d", want.distance, distance);
                error_count++;
            end
        endfunction

        function int pending_count();
            return pending_answers.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_req_valid;
    logic              o_req_stall;
    logic              i_req_type;
    logic [NODE_W-1:0] i_node_a;
    logic [NODE_W-1:0] i_node_b;
    logic              o_rsp_valid;
    logic              i_rsp_stall = 1'b0;
    logic [NODE_W-1:0] o_common_ancestor;
    logic [DIST_W-1:0] o_path_distance;

    t_lca_scoreboard scoreboard = new();

    int        requests_sent = 0;
    int        burst_left = 0;
    int        cycle_count = 0;
    t_rsp_mode rsp_mode = RSP_FREE;
    int        rsp_stretch_left = 0;

    lca_binary_lifting_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req_valid),
        .o_req_stall       (o_req_stall),
        .i_req_type        (i_req_type),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_stall       (i_rsp_stall),
        .o_common_ancestor (o_common_ancestor),
        .o_path_distance   (o_path_distance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: the run also covers the memory sweep after reset
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: alternate free stretches, solid holds and random stalls.
    // The pattern ignores o_rsp_valid so stalls land on every state of the core.
    always @(posedge i_clk) begin
        if (rsp_stretch_left == 0) begin
            rsp_mode         = t_rsp_mode'($urandom_range(0, 2));
            rsp_stretch_left = $urandom_range(1, 40);
        end
        rsp_stretch_left--;
        case (rsp_mode)
            RSP_FREE:  i_rsp_stall <= 1'b0;
            RSP_HOLD:  i_rsp_stall <= 1'b1;
            default:   i_rsp_stall <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Monitor: sample both handshakes at the edge, before the edge's updates land.
    // Check the response first; a query taken at this edge cannot answer at it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall)
                scoreboard.check_response(o_common_ancestor, o_path_distance);
            if (i_req_valid && !o_req_stall)
                scoreboard.note_request(i_req_type, i_node_a, i_node_b);
        end
    end

    // Present one request and hold it until the core takes it.
    // Bursts of random length; between bursts drop valid for a random gap.
    task automatic send_request(input bit kind, input bit [NODE_W-1:0] a,
                                input bit [NODE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_req_valid <= 1'b1;
        i_req_type  <= kind;
        i_node_a    <= a;
        i_node_b    <= b;
        do @(posedge i_clk); while (o_req_stall);
        requests_sent++;
    endtask

    task automatic load_node(input bit [NODE_W-1:0] node, input bit [NODE_W-1:0] parent);
        send_request(REQ_LOAD, node, parent);
    endtask

    task automatic ask_query(input bit [NODE_W-1:0] a, input bit [NODE_W-1:0] b);
        send_request(REQ_QUERY, a, b);
    endtask

    // Random forest: parents are the sentinel or come from earlier loads of this round, so the rows
    // stay consistent; a few noise requests and stray queries are mixed in.
    task automatic grow_forest();
        bit [NODE_W-1:0] grove [256];
        int              n;
        int              i;
        int              j;
        bit [NODE_W-1:0] parent;
        bit [NODE_W-1:0] qa;
        bit [NODE_W-1:0] qb;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(2, 24);
        for (i = 0; i < n; i++) begin
            grove[i] = NODE_W'($urandom_range(1, NODES - 1));
            if (i == 0 || $urandom_range(0, 5) == 0)
                parent = '0;
            else if ($urandom_range(0, 1) == 0)
                parent = grove[i-1];
            else
                parent = grove[$urandom_range(0, i - 1)];
            load_node(grove[i], parent);
            if ($urandom_range(0, 11) == 0)
                send_request(1'($urandom_range(0, 1)), NODE_W'($urandom_range(0, NODES - 1)),
                             NODE_W'($urandom_range(0, NODES - 1)));
            if ($urandom_range(0, 2) == 0)
                ask_query(grove[$urandom_range(0, i)], grove[$urandom_range(0, i)]);
        end
        for (j = 0; j <= n / 2; j++) begin
            qa = grove[$urandom_range(0, n - 1)];
            qb = ($urandom_range(0, 9) == 0) ? NODE_W'($urandom_range(0, NODES - 1))
                                             : grove[$urandom_range(0, n - 1)];
            ask_query(qa, qb);
        end
    endtask

    initial begin
        bit [NODE_W-1:0] chain [NODES-1];
        bit [NODE_W-1:0] swap;
        int              i;
        int              j;

        i_req_valid <= 1'b0;
        i_req_type  <= REQ_LOAD;
        i_node_a    <= '0;
        i_node_b    <= '0;
        i_rst_n     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tables, sentinel, ignored load of node zero, a small tree
        ask_query('0, '0);
        ask_query(10'd1023, 10'd5);
        load_node('0, 10'd7);
        load_node(10'd1, '0);
        load_node(10'd2, 10'd1);
        load_node(10'd3, 10'd1);
        load_node(10'd4, 10'd2);
        load_node(10'd1023, 10'd4);
        load_node(10'd512, 10'd3);
        ask_query(10'd1023, 10'd512);
        ask_query(10'd4, 10'd3);
        ask_query(10'd1023, 10'd1023);
        ask_query(10'd1, 10'd1023);
        ask_query(10'd1023, '0);
        // Second root: nodes in different trees meet at the sentinel
        load_node(10'd700, '0);
        load_node(10'd341, 10'd700);
        ask_query(10'd341, 10'd1023);
        ask_query(10'd85, 10'd341);
        // Reload into a cycle, then query the now inconsistent rows
        load_node(10'd1, 10'd1023);
        load_node(10'd2, 10'd2);
        ask_query(10'd1, 10'd1023);
        ask_query(10'd2, 10'd512);
        ask_query(10'd4, 10'd3);

        // One chain through every node in shuffled order: reaches the top lift levels
        for (i = 0; i < NODES - 1; i++)
            chain[i] = NODE_W'(i + 1);
        for (i = NODES - 2; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = chain[i];
            chain[i] = chain[j];
            chain[j] = swap;
        end
        for (i = 0; i < NODES - 1; i++) begin
            load_node(chain[i], (i == 0) ? '0 : chain[i-1]);
            if ($urandom_range(0, 15) == 0)
                ask_query(chain[$urandom_range(0, i)], chain[$urandom_range(0, i)]);
        end
        ask_query(chain[NODES-2], chain[0]);
        ask_query(chain[NODES-2], chain[511]);
        ask_query(chain[512], chain[NODES-2]);
        for (i = 0; i < 30; i++)
            ask_query(chain[$urandom_range(0, NODES - 2)], chain[$urandom_range(0, NODES - 2)]);
        // Hang the root under the deepest node: depth saturates, twice over
        load_node(chain[0], chain[NODES-2]);
        load_node(chain[1], chain[0]);
        ask_query(chain[0], chain[NODES-2]);
        ask_query(chain[1], chain[NODES-2]);
        ask_query(chain[0], chain[1]);
        for (i = 0; i < 8; i++)
            ask_query(chain[$urandom_range(0, 3)], chain[$urandom_range(0, NODES - 2)]);

        while (requests_sent < ITEM_TARGET)
            grow_forest();

        // Drain: let the monitor log the last request, wait for every answer, then
        // give a trailing load time to finish
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.error_count == 0 && scoreboard.pending_count() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
